>>> hdl/hrle_pkg.sv
// shared constants, codes and control types for the run-length huffman encoder
`timescale 1ns / 1ps

package hrle_pkg;

  localparam int SYMBOL_BITS  = 16;
  localparam int MAX_CODE_LEN = 58;
  localparam int MAX_REPEAT   = 255;
  localparam int TABLE_DEPTH  = (1 << SYMBOL_BITS) + 1;
  localparam int ADDR_W       = $clog2(TABLE_DEPTH);
  localparam int LEN_W        = 6;
  localparam int ENTRY_W      = MAX_CODE_LEN + LEN_W;
  localparam int COUNT_W      = 8;
  localparam int TOTAL_W      = 32;
  localparam int MAX_RESULTS  = 24;
  localparam int RES_W        = $clog2(MAX_RESULTS + 1);

  localparam logic [ADDR_W-1:0] ESC_RESET   = ADDR_W'(1 << SYMBOL_BITS);
  localparam logic [ADDR_W-1:0] LAST_INDEX  = ADDR_W'(TABLE_DEPTH - 1);
  localparam logic [LEN_W-1:0]  LEN_LIMIT   = LEN_W'(MAX_CODE_LEN);
  localparam logic [COUNT_W-1:0] REPEAT_LIM = COUNT_W'(MAX_REPEAT);

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_END    = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_SYM,
    ST_RD_ESC,
    ST_CAP_ESC,
    ST_DECIDE,
    ST_SYM,
    ST_ESC,
    ST_CNT,
    ST_AFTER,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic latch;
    logic tbl_write;
    logic rd_sym;
    logic rd_esc;
    logic cap_sym;
    logic cap_esc;
    logic decide;
    logic load_sym;
    logic load_esc;
    logic load_cnt;
    logic step;
    logic next_rep;
    logic hold_new;
    logic inc_rep;
    logic emit_final;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  holding;
    logic  same_run;
    logic  shift_idle;
    logic  use_esc;
    logic  rep_done;
    logic  out_free;
  } stat_t;

endpackage

>>> hdl/hrle_if.sv
// request channel interfaces for input items, results and the escape register
`timescale 1ns / 1ps

interface hrle_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [16:0] entry_index;
  logic [5:0]  code_length;
  logic [57:0] code_value;
  logic [15:0] symbol;
  modport source (output valid, mode, entry_index, code_length, code_value, symbol,
                  input ready);
  modport sink (input valid, mode, entry_index, code_length, code_value, symbol,
                output ready);
endinterface

interface hrle_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_present;
  logic        last;
  logic [31:0] total_bits;
  modport source (output valid, out_byte, byte_present, last, total_bits, input ready);
  modport sink (input valid, out_byte, byte_present, last, total_bits, output ready);
endinterface

interface hrle_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] run_escape_symbol;
  modport source (output valid, run_escape_symbol, input ready);
  modport sink (input valid, run_escape_symbol, output ready);
endinterface

>>> hdl/huffman_run_length_symbol_encoder.sv
// top level of the huffman encoder with run-length escape
//
//  channel  | dir | carries
//  ---------+-----+------------------------------------------------------
//  in_ch    | in  | mode, entry_index, code_length, code_value, symbol
//  out_ch   | out | out_byte, byte_present, last, total_bits
//  cfg_ch   | in  | run_escape_symbol
//
// a load or an absorbed repeat passes through the idle and exec states; a run
// that closes reads the symbol and escape entries and decides, then per code
// loads it and steps the packer by up to 8 bits at a time, then closes; an end adds a final state.
// reset is synchronous; the code table holds no reset value.
// a stalled output stops the packer; one result waits in the output register.
`timescale 1ns / 1ps

module huffman_run_length_symbol_encoder (
  input logic       clk,
  input logic       rst,
  hrle_in_if.sink   in_ch,
  hrle_out_if.source out_ch,
  hrle_cfg_if.sink  cfg_ch
);
  import hrle_pkg::*;

  cmd_t   cmd;
  stat_t  stat;
  state_t state;
  logic   in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  // controller
  hrle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd),
    .state    (state)
  );

  // datapath
  hrle_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_ch.valid),
    .cfg_data     (cfg_ch.run_escape_symbol),
    .in_mode      (in_ch.mode),
    .in_index     (in_ch.entry_index),
    .in_length    (in_ch.code_length),
    .in_code      (in_ch.code_value),
    .in_symbol    (in_ch.symbol),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_byte     (out_ch.out_byte),
    .byte_present (out_ch.byte_present),
    .last         (out_ch.last),
    .total_bits   (out_ch.total_bits)
  );

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("new request taken while an item is in work");

  // packed bytes carry data and no total
  a_byte_result: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.last |-> out_ch.byte_present && (out_ch.total_bits == '0))
    else $error("mid-stream result malformed");

  // an empty final result carries a zero byte
  a_empty_final: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.last && !out_ch.byte_present |-> (out_ch.out_byte == 8'd0))
    else $error("empty final result carries data");

  // the packer only runs while a run is being sent
  a_step_state: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (state == ST_SYM) || (state == ST_ESC) || (state == ST_CNT))
    else $error("packer stepped outside run output");

endmodule

>>> hdl/hrle_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module hrle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/hrle_ctrl.sv
// sequencing state machine of the encoder
`timescale 1ns / 1ps

module hrle_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  hrle_pkg::stat_t stat,
  output hrle_pkg::cmd_t  cmd,
  output hrle_pkg::state_t state
);
  import hrle_pkg::*;

  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat.mode)
          MODE_LOAD: begin
            cmd.tbl_write = 1'b1;
            state_next    = ST_IDLE;
          end
          MODE_ENCODE: begin
            if (!stat.holding) begin
              cmd.hold_new = 1'b1;
              state_next   = ST_IDLE;
            end else if (stat.same_run) begin
              cmd.inc_rep = 1'b1;
              state_next  = ST_IDLE;
            end else begin
              state_next = ST_RD_SYM;
            end
          end
          MODE_END: begin
            state_next = stat.holding ? ST_RD_SYM : ST_FINAL;
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_RD_SYM: begin
        cmd.rd_sym = 1'b1;
        state_next = ST_RD_ESC;
      end
      ST_RD_ESC: begin
        cmd.rd_esc  = 1'b1;
        cmd.cap_sym = 1'b1;
        state_next  = ST_CAP_ESC;
      end
      ST_CAP_ESC: begin
        cmd.cap_esc = 1'b1;
        state_next  = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide   = 1'b1;
        cmd.load_sym = 1'b1;
        state_next   = ST_SYM;
      end
      ST_SYM: begin
        if (!stat.shift_idle) begin
          cmd.step = 1'b1;
        end else if (stat.use_esc) begin
          cmd.load_esc = 1'b1;
          state_next   = ST_ESC;
        end else if (stat.rep_done) begin
          state_next = ST_AFTER;
        end else begin
          cmd.next_rep = 1'b1;
          cmd.load_sym = 1'b1;
        end
      end
      ST_ESC: begin
        if (!stat.shift_idle) begin
          cmd.step = 1'b1;
        end else begin
          cmd.load_cnt = 1'b1;
          state_next   = ST_CNT;
        end
      end
      ST_CNT: begin
        if (!stat.shift_idle) begin
          cmd.step = 1'b1;
        end else begin
          state_next = ST_AFTER;
        end
      end
      ST_AFTER: begin
        if (stat.mode == MODE_ENCODE) begin
          cmd.hold_new = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (stat.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/hrle_datapath.sv
// run state, code table, bit packer and result register of the encoder
`timescale 1ns / 1ps

module hrle_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [hrle_pkg::ADDR_W-1:0]        cfg_data,
  input  logic [1:0]                         in_mode,
  input  logic [hrle_pkg::ADDR_W-1:0]        in_index,
  input  logic [hrle_pkg::LEN_W-1:0]         in_length,
  input  logic [hrle_pkg::MAX_CODE_LEN-1:0]  in_code,
  input  logic [hrle_pkg::SYMBOL_BITS-1:0]   in_symbol,
  input  hrle_pkg::cmd_t                     cmd,
  output hrle_pkg::stat_t                    stat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         out_byte,
  output logic                               byte_present,
  output logic                               last,
  output logic [hrle_pkg::TOTAL_W-1:0]       total_bits
);
  import hrle_pkg::*;

  logic [ADDR_W-1:0]       esc_idx;
  mode_t                   mode_r;
  logic [ADDR_W-1:0]       idx_r;
  logic [LEN_W-1:0]        len_r;
  logic [MAX_CODE_LEN-1:0] val_r;
  logic [SYMBOL_BITS-1:0]  sym_r;

  logic [SYMBOL_BITS-1:0]  held;
  logic                    holding;
  logic [COUNT_W-1:0]      rc;
  logic [COUNT_W-1:0]      rep_k;
  logic                    use_esc;
  logic                    esc_oob;
  logic [ENTRY_W-1:0]      sym_ent;
  logic [ENTRY_W-1:0]      esc_ent;

  logic [LEN_W-1:0]        rem;
  logic [MAX_CODE_LEN-1:0] code_r;
  logic [6:0]              pbits;
  logic [2:0]              pcnt;
  logic [TOTAL_W-1:0]      total;
  logic [RES_W-1:0]        res_n;

  // table write and read
  logic [LEN_W-1:0]        clamp_len;
  logic [MAX_CODE_LEN-1:0] code_mask;
  logic [ENTRY_W-1:0]      wr_word;
  logic                    ram_we;
  logic [ADDR_W-1:0]       raddr;
  logic [ENTRY_W-1:0]      rdata;

  assign clamp_len = (len_r > LEN_LIMIT) ? LEN_LIMIT : len_r;
  assign code_mask = (MAX_CODE_LEN'(1) << clamp_len) - MAX_CODE_LEN'(1);
  assign wr_word   = {val_r & code_mask, clamp_len};
  assign ram_we    = cmd.tbl_write && (idx_r <= LAST_INDEX);
  assign raddr     = cmd.rd_sym ? ADDR_W'(held) : esc_idx;

  hrle_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (wr_word),
    .raddr (raddr),
    .rdata (rdata)
  );

  // cost of escape form against repeated codes
  logic [LEN_W-1:0] ls;
  logic [LEN_W-1:0] le;
  logic [13:0]      esc_cost;
  logic [13:0]      rep_cost;

  assign ls       = sym_ent[LEN_W-1:0];
  assign le       = esc_ent[LEN_W-1:0];
  assign esc_cost = 14'(ls) + 14'(le) + 14'd8;
  assign rep_cost = 14'(ls) * 14'(rc);

  // bit packer: up to one byte's worth of bits per cycle, unless a full byte waits for the output register
  logic [3:0]              avail;
  logic [3:0]              take;
  logic [LEN_W-1:0]        rem_after;
  logic [MAX_CODE_LEN-1:0] shifted;
  logic [7:0]              chunk;
  logic [7:0]              merged;
  logic [3:0]              new_cnt;
  logic                    full;
  logic                    emit_byte;
  logic                    out_free;
  logic                    step_go;
  logic                    res_room;

  assign avail     = 4'd8 - 4'(pcnt);
  assign take      = (rem < LEN_W'(avail)) ? rem[3:0] : avail;
  assign rem_after = rem - LEN_W'(take);
  assign shifted   = code_r >> rem_after;
  assign chunk     = shifted[7:0] & ((8'd1 << take) - 8'd1);
  assign merged    = (8'(pbits) << take) | chunk;
  assign new_cnt   = 4'(pcnt) + take;
  assign full      = (new_cnt == 4'd8);
  assign res_room  = (res_n < RES_W'(MAX_RESULTS));
  assign emit_byte = full && res_room;
  assign out_free  = !out_valid || out_ready;
  assign step_go   = cmd.step && (rem != '0) && (!emit_byte || out_free);

  // padded last byte
  logic [7:0] pad_byte;
  assign pad_byte = 8'(8'(pbits) << (4'd8 - 4'(pcnt)));

  // status to the controller
  assign stat.mode       = mode_r;
  assign stat.holding    = holding;
  assign stat.same_run   = (sym_r == held) && (rc < REPEAT_LIM);
  assign stat.shift_idle = (rem == '0);
  assign stat.use_esc    = use_esc;
  assign stat.rep_done   = (rep_k == rc);
  assign stat.out_free   = out_free;

  // escape register
  always_ff @(posedge clk) begin
    if (rst) begin
      esc_idx <= ESC_RESET;
    end else if (cfg_valid) begin
      esc_idx <= cfg_data;
    end
  end

  // input item capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= mode_t'(in_mode);
      idx_r  <= in_index;
      len_r  <= in_length;
      val_r  <= in_code;
      sym_r  <= in_symbol;
    end
  end

  // entry capture and decision
  always_ff @(posedge clk) begin
    if (cmd.cap_sym) begin
      sym_ent <= rdata;
    end
    if (cmd.rd_esc) begin
      esc_oob <= (esc_idx > LAST_INDEX);
    end
    if (cmd.cap_esc) begin
      esc_ent <= esc_oob ? '0 : rdata;
    end
    if (cmd.decide) begin
      use_esc <= (esc_cost < rep_cost);
    end
    if (cmd.decide) begin
      rep_k <= '0;
    end else if (cmd.next_rep) begin
      rep_k <= rep_k + COUNT_W'(1);
    end
  end

  // run state and bit packer state
  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= '0;
      holding <= 1'b0;
      rc      <= '0;
      rem     <= '0;
      pbits   <= '0;
      pcnt    <= '0;
      total   <= '0;
      res_n   <= '0;
    end else begin
      if (cmd.latch) begin
        res_n <= '0;
      end else if (step_go && emit_byte) begin
        res_n <= res_n + RES_W'(1);
      end
      if (cmd.hold_new) begin
        held    <= sym_r;
        holding <= 1'b1;
        rc      <= '0;
      end else if (cmd.inc_rep) begin
        rc <= rc + COUNT_W'(1);
      end
      // code loads add their length to the running total
      if (cmd.load_sym) begin
        code_r <= sym_ent[ENTRY_W-1:LEN_W];
        rem    <= ls;
        total  <= total + TOTAL_W'(ls);
      end else if (cmd.load_esc) begin
        code_r <= esc_ent[ENTRY_W-1:LEN_W];
        rem    <= le;
        total  <= total + TOTAL_W'(le);
      end else if (cmd.load_cnt) begin
        code_r <= MAX_CODE_LEN'(rc);
        rem    <= LEN_W'(COUNT_W);
        total  <= total + TOTAL_W'(COUNT_W);
      end else if (step_go) begin
        rem <= rem_after;
        if (full) begin
          pbits <= '0;
          pcnt  <= '0;
        end else begin
          pbits <= merged[6:0];
          pcnt  <= new_cnt[2:0];
        end
      end
      // end of stream returns run and bit state to reset
      if (cmd.emit_final) begin
        held    <= '0;
        holding <= 1'b0;
        rc      <= '0;
        pbits   <= '0;
        pcnt    <= '0;
        total   <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((step_go && emit_byte) || (cmd.emit_final && res_room)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && emit_byte) begin
      out_byte     <= merged;
      byte_present <= 1'b1;
      last         <= 1'b0;
      total_bits   <= '0;
    end else if (cmd.emit_final && res_room) begin
      out_byte     <= (pcnt != '0) ? pad_byte : 8'd0;
      byte_present <= (pcnt != '0);
      last         <= 1'b1;
      total_bits   <= total;
    end
  end

endmodule

>>> bench/huffman_run_length_symbol_encoder_test.sv
// self-checking bench for the run-length huffman encoder: predictor, driver, monitor
`timescale 1ns / 1ps

module huffman_run_length_symbol_encoder_test;
  import hrle_pkg::*;

  typedef struct packed {
    mode_t       mode;
    logic [16:0] entry_index;
    logic [5:0]  code_length;
    logic [57:0] code_value;
    logic [15:0] symbol;
  } enc_req_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_present;
    logic        last;
    logic [31:0] total_bits;
  } enc_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hrle_in_if  in_ch ();
  hrle_out_if out_ch ();
  hrle_cfg_if cfg_ch ();

  huffman_run_length_symbol_encoder DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [63:0] code_tbl [0:TABLE_DEPTH-1];
  logic [16:0] esc_index;
  logic [15:0] run_sym;
  logic        run_open;
  logic [7:0]  run_reps;
  logic [7:0]  acc_bits;
  int unsigned acc_count;
  logic [31:0] bits_sent;

  enc_req_t pending_reqs [$];
  enc_res_t expected_bytes [$];
  int errors = 0;
  int unsigned cycle = 0;

  // idling controls
  bit src_calm = 0, snk_calm = 0;
  bit sink_hold = 0;
  int unsigned hold_len = 0;
  bit src_pause = 0;

  function automatic logic [63:0] lookup_code(input logic [16:0] idx);
    if (idx >= TABLE_DEPTH) return 64'd0;
    return code_tbl[idx];
  endfunction

  task automatic shift_in_bits(input int unsigned n, input logic [63:0] bits);
    enc_res_t r;
    for (int i = n; i > 0; i--) begin
      acc_bits = {acc_bits[6:0], bits[i-1]};
      acc_count++;
      if (acc_count == 8) begin
        r = '{acc_bits, 1'b1, 1'b0, 32'd0};
        expected_bytes.push_back(r);
        acc_bits = 0;
        acc_count = 0;
      end
    end
    bits_sent += n;
  endtask

  task automatic close_run();
    logic [63:0] s, e;
    int unsigned ls, le;
    s = lookup_code({1'b0, run_sym});
    e = lookup_code(esc_index);
    ls = s[5:0];
    le = e[5:0];
    if (ls + le + 8 < ls * run_reps) begin
      shift_in_bits(ls, s >> 6);
      shift_in_bits(le, e >> 6);
      shift_in_bits(8, {56'd0, run_reps});
    end else begin
      for (int k = 0; k <= run_reps; k++) shift_in_bits(ls, s >> 6);
    end
  endtask

  task automatic predict_request(input enc_req_t q);
    int unsigned len;
    logic [57:0] code;
    enc_res_t r;
    case (q.mode)
      MODE_LOAD: begin
        if (q.entry_index < TABLE_DEPTH) begin
          len = (q.code_length > MAX_CODE_LEN) ? MAX_CODE_LEN : q.code_length;
          code = q.code_value & ((58'd1 << len) - 1);
          code_tbl[q.entry_index] = {code, 6'(len)};
        end
      end
      MODE_ENCODE: begin
        if (!run_open) begin
          run_open = 1; run_sym = q.symbol; run_reps = 0;
        end else if (q.symbol == run_sym && run_reps < MAX_REPEAT) begin
          run_reps++;
        end else begin
          close_run();
          run_sym = q.symbol; run_reps = 0;
        end
      end
      MODE_END: begin
        if (run_open) close_run();
        if (acc_count > 0) r = '{8'(acc_bits << (8 - acc_count)), 1'b1, 1'b1, bits_sent};
        else r = '{8'd0, 1'b0, 1'b1, bits_sent};
        expected_bytes.push_back(r);
        run_sym = 0; run_open = 0; run_reps = 0;
        acc_bits = 0; acc_count = 0; bits_sent = 0;
      end
      default: ;
    endcase
  endtask

  // request builders
  function automatic enc_req_t load_req(input logic [16:0] idx, input logic [5:0] len,
                                        input logic [57:0] code);
    enc_req_t q;
    q = '{MODE_LOAD, idx, len, code, 16'($urandom)};
    return q;
  endfunction

  function automatic enc_req_t sym_req(input logic [15:0] s);
    return '{MODE_ENCODE, 17'($urandom), 6'($urandom), {26'($urandom), 32'($urandom)}, s};
  endfunction

  function automatic enc_req_t end_req();
    return '{MODE_END, 17'($urandom), 6'($urandom), 58'd0, 16'($urandom)};
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid && in_ch.ready) void'(pending_reqs.pop_front());
      if (pending_reqs.size() > 0 && !src_pause && (src_calm || $urandom_range(99) >= 18))
      begin
        in_ch.valid <= 1'b1;
        {in_ch.mode, in_ch.entry_index, in_ch.code_length, in_ch.code_value, in_ch.symbol}
          <= pending_reqs[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // predict on accepted requests
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      predict_request({mode_t'(in_ch.mode), in_ch.entry_index, in_ch.code_length,
                       in_ch.code_value, in_ch.symbol});
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_len > 0) begin
      sink_hold <= 1'b1;
      hold_len <= hold_len - 1;
    end else begin
      sink_hold <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    enc_res_t got, want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.out_byte, out_ch.byte_present, out_ch.last, out_ch.total_bits};
        if (expected_bytes.size() == 0) begin
          $error("unexpected result byte=%0h", got.out_byte);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte expected %0h actual %0h", want.out_byte, got.out_byte); errors++;
          end
          if (got.byte_present !== want.byte_present) begin
            $error("byte_present expected %0d actual %0d", want.byte_present,
                   got.byte_present); errors++;
          end
          if (got.last !== want.last) begin
            $error("last expected %0d actual %0d", want.last, got.last); errors++;
          end
          if (got.total_bits !== want.total_bits) begin
            $error("total_bits expected %0d actual %0d", want.total_bits,
                   got.total_bits); errors++;
          end
        end
      end
      out_ch.ready <= !sink_hold && (snk_calm || $urandom_range(99) >= 18);
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 400000) begin
      $display("** huffman_run_length_symbol_encoder: FAILED **");
      $finish;
    end
  end

  task automatic write_escape(input logic [16:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.run_escape_symbol <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    esc_index = v;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_bytes.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // random stream over a small set of loaded symbols
  task automatic random_phase(input int n);
    logic [15:0] syms [8];
    logic [15:0] s;
    int reps;
    for (int i = 0; i < 8; i++) begin
      syms[i] = 16'($urandom);
      pending_reqs.push_back(load_req({1'b0, syms[i]}, 6'($urandom_range(63)),
                                      {26'($urandom), 32'($urandom)}));
    end
    while (n > 0) begin
      s = syms[$urandom_range(7)];
      reps = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(4);
      for (int k = 0; k <= reps && n > 0; k++) begin
        pending_reqs.push_back(sym_req(s));
        n--;
      end
      if ($urandom_range(15) == 0) begin pending_reqs.push_back(end_req()); n--; end
      if ($urandom_range(30) == 0) begin
        pending_reqs.push_back('{MODE_NONE, 17'($urandom), 6'($urandom), 58'($urandom),
                                 16'($urandom)});
        n--;
      end
    end
    pending_reqs.push_back(end_req());
  endtask

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      code_tbl[i] = 64'd0;
    end
    esc_index = ESC_RESET;
    run_sym = 0; run_open = 0; run_reps = 0;
    acc_bits = 0; acc_count = 0; bits_sent = 0;
    in_ch.valid = 1'b0; in_ch.mode = MODE_NONE; in_ch.entry_index = '0;
    in_ch.code_length = '0; in_ch.code_value = '0; in_ch.symbol = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.run_escape_symbol = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty stream, extremes, overlong and zero lengths
    pending_reqs.push_back(end_req());
    pending_reqs.push_back(load_req(17'h10000, 6'd5, 58'h3ff));
    pending_reqs.push_back(load_req(17'h1ffff, 6'd9, 58'h1ff));
    pending_reqs.push_back(load_req(17'd0, 6'd63, '1));
    pending_reqs.push_back(load_req(17'hffff, 6'd0, 58'h55));
    pending_reqs.push_back(load_req(17'd7, 6'd3, 58'h5));
    pending_reqs.push_back('{MODE_NONE, '1, '1, '1, '1});
    pending_reqs.push_back(sym_req(16'd0));
    pending_reqs.push_back(sym_req(16'hffff));
    pending_reqs.push_back(sym_req(16'hffff));
    for (int i = 0; i < 6; i++) pending_reqs.push_back(sym_req(16'd7));
    pending_reqs.push_back(sym_req(16'd0));
    pending_reqs.push_back(end_req());
    drain();

    // escape at index 7, one long run; receiver holds off long
    write_escape(17'd7);
    pending_reqs.push_back(load_req(17'd3, 6'd12, 58'habc));
    for (int i = 0; i < 80; i++) pending_reqs.push_back(sym_req(16'd3));
    pending_reqs.push_back(end_req());
    hold_len = 300;
    drain();

    // escape index out of range, then minimum, then the last table index
    write_escape(17'h1ffff);
    src_calm = 1; snk_calm = 1;
    random_phase(25);
    drain();
    src_calm = 0; snk_calm = 0;
    write_escape(17'd0);
    random_phase(30);
    // sender pause until every result is in
    while (pending_reqs.size() > 15) @(posedge clk);
    src_pause = 1;
    while (in_ch.valid) @(posedge clk);
    while (expected_bytes.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    src_pause = 0;
    drain();
    write_escape(17'h10000);
    random_phase(25);
    drain();

    if (errors == 0) $display("** huffman_run_length_symbol_encoder: PASSED **");
    else $display("** huffman_run_length_symbol_encoder: FAILED **");
    $finish;
  end
endmodule

>>> huffman_run_length_symbol_encoder.f
hdl/hrle_pkg.sv
hdl/hrle_if.sv
hdl/hrle_ram.sv
hdl/hrle_ctrl.sv
hdl/hrle_datapath.sv
hdl/huffman_run_length_symbol_encoder.sv
bench/huffman_run_length_symbol_encoder_test.sv
